[hw/rtl/gbm_pkg.sv]
package gbm_pkg;

  // defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEFAULT        = 16;
  localparam int COEF_FRACTION_BITS_DEFAULT = 14;
  localparam int STATE_BITS_DEFAULT         = 48;

  // fixed widths
  localparam int COEF_BITS   = 16;
  localparam int MAG_BITS    = 48;

  // block results waiting between recurrence and power/root stage
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL_C,
    BK_MUL_CS,
    BK_MUL_SQ1,
    BK_MUL_SQ2,
    BK_PREP,
    BK_ROOT,
    BK_DONE
  } back_state_t;

endpackage

[hw/rtl/gbm_front.sv]
module gbm_front #(
  parameter int SAMPLE_BITS        = gbm_pkg::SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRACTION_BITS = gbm_pkg::COEF_FRACTION_BITS_DEFAULT,
  parameter int STATE_BITS         = gbm_pkg::STATE_BITS_DEFAULT,
  localparam int ENTRY_BITS        = 2 * STATE_BITS + gbm_pkg::COEF_BITS + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [SAMPLE_BITS-1:0]       sample,
  input  logic                                last_sample,
  input  logic                                cfg_write,
  input  logic signed [gbm_pkg::COEF_BITS-1:0] cfg_data,
  output logic                                q_push,
  input  logic                                q_full,
  output logic [ENTRY_BITS-1:0]               q_data
);

  localparam int PROD_BITS = STATE_BITS + gbm_pkg::COEF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;

  logic signed [gbm_pkg::COEF_BITS-1:0] coef;
  logic signed [STATE_BITS-1:0]         delay_one;
  logic signed [STATE_BITS-1:0]         delay_two;
  logic                                 overflow_seen;

  logic signed [PROD_BITS-1:0]  prod;
  logic signed [PROD_BITS-1:0]  prod_scaled;
  logic signed [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-STATE_BITS:0] sum_top;
  logic                         clip_now;
  logic signed [STATE_BITS-1:0] s_sat;
  logic                         take;

  assign take = push && !q_full;
  assign full = q_full;

  // c * s1, floor-scaled back to state units
  assign prod        = coef * delay_one;
  assign prod_scaled = prod >>> COEF_FRACTION_BITS;
  assign sum = SUM_BITS'(sample) + SUM_BITS'(prod_scaled) - SUM_BITS'(delay_two);

  assign sum_top  = sum[SUM_BITS-1:STATE_BITS-1];
  assign clip_now = !((&sum_top) || (~|sum_top));

  always_comb begin
    if (!clip_now) begin
      s_sat = sum[STATE_BITS-1:0];
    end else if (sum[SUM_BITS-1]) begin
      s_sat = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      s_sat = {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  end

  assign q_push = take && last_sample;
  assign q_data = {overflow_seen | clip_now, coef, delay_one, s_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      coef          <= '0;
      delay_one     <= '0;
      delay_two     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_write) begin
        coef <= cfg_data;
      end
      if (take) begin
        if (last_sample) begin
          delay_one     <= '0;
          delay_two     <= '0;
          overflow_seen <= 1'b0;
        end else begin
          delay_two     <= delay_one;
          delay_one     <= s_sat;
          overflow_seen <= overflow_seen | clip_now;
        end
      end
    end
  end

endmodule

[hw/rtl/gbm_queue.sv]
module gbm_queue #(
  parameter int DEPTH = gbm_pkg::QUEUE_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]      slots [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] fill;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (fill == COUNT_BITS'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - COUNT_BITS'(1);
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= COUNT_BITS'(DEPTH))
    else $error("queue fill beyond depth");

endmodule

[hw/rtl/gbm_back.sv]
module gbm_back #(
  parameter int COEF_FRACTION_BITS = gbm_pkg::COEF_FRACTION_BITS_DEFAULT,
  parameter int STATE_BITS         = gbm_pkg::STATE_BITS_DEFAULT,
  localparam int ENTRY_BITS        = 2 * STATE_BITS + gbm_pkg::COEF_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  logic [ENTRY_BITS-1:0]        q_rdata,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [gbm_pkg::MAG_BITS-1:0] magnitude,
  output logic                         saturated
);

  localparam int CB   = gbm_pkg::COEF_BITS;
  localparam int MB   = gbm_pkg::MAG_BITS;
  localparam int FB   = COEF_FRACTION_BITS;
  localparam int SB   = STATE_BITS;
  localparam int PW   = 2 * SB + ((FB > CB) ? FB : CB) + 2;
  localparam int EW   = PW + 2 * MB;
  localparam int RAD  = 2 * MB;
  localparam int RW   = MB + 2;
  localparam int CW   = $clog2(((SB > MB) ? SB : MB) + 1);

  gbm_pkg::back_state_t state, state_next;

  logic [SB-1:0] e_s1, e_s2, e_a1, e_a2;
  logic [CB-1:0] e_c, e_ac;
  logic          e_ovf;

  logic [CW-1:0] count;
  logic [PW-1:0] acc, mcand, addend, acc_step;
  logic [SB-1:0] mplier, abs1, abs2;
  logic          mul_sub, neg_cs, ovf_blk, clip;
  logic          step_last, out_load, out_valid;

  logic [EW-1:0]    pext;
  logic [EW-FB-1:0] q_hi;
  logic             clip_c;

  logic [RAD-1:0] rad;
  logic [RW-1:0]  rem, rem_next;
  logic [MB-1:0]  root, root_next;
  logic [RW+1:0]  rem_sh, trial, rem_diff;
  logic           ge;

  // entry layout: {ovf, coef, s2, s1}
  assign e_s1  = q_rdata[SB-1:0];
  assign e_s2  = q_rdata[2*SB-1:SB];
  assign e_c   = q_rdata[2*SB+CB-1:2*SB];
  assign e_ovf = q_rdata[ENTRY_BITS-1];
  assign e_a1  = e_s1[SB-1] ? (~e_s1 + SB'(1)) : e_s1;
  assign e_a2  = e_s2[SB-1] ? (~e_s2 + SB'(1)) : e_s2;
  assign e_ac  = e_c[CB-1] ? (~e_c + CB'(1)) : e_c;

  // shift-add step, one multiplier bit a cycle
  assign step_last = (count == CW'(1));
  assign addend    = mplier[0] ? mcand : '0;
  assign acc_step  = mul_sub ? (acc - addend) : (acc + addend);

  // power scaled back by 2^F, clamped to the root's input range
  assign pext   = {{(2 * MB){acc[PW-1]}}, acc};
  assign q_hi   = pext[EW-1:FB];
  assign clip_c = !acc[PW-1] && (|q_hi[EW-FB-1:RAD]);

  // restoring square root, two radicand bits a step
  assign rem_sh    = {rem, rad[RAD-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign ge        = (rem_sh >= trial);
  assign rem_diff  = rem_sh - trial;
  assign rem_next  = ge ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
  assign root_next = {root[MB-2:0], ge};

  always_comb begin
    state_next = state;
    case (state)
      gbm_pkg::BK_IDLE: begin
        if (!q_empty) state_next = gbm_pkg::BK_MUL_C;
      end
      gbm_pkg::BK_MUL_C: begin
        if (step_last) state_next = gbm_pkg::BK_MUL_CS;
      end
      gbm_pkg::BK_MUL_CS: begin
        if (step_last) state_next = gbm_pkg::BK_MUL_SQ1;
      end
      gbm_pkg::BK_MUL_SQ1: begin
        if (step_last) state_next = gbm_pkg::BK_MUL_SQ2;
      end
      gbm_pkg::BK_MUL_SQ2: begin
        if (step_last) state_next = gbm_pkg::BK_PREP;
      end
      gbm_pkg::BK_PREP: begin
        state_next = gbm_pkg::BK_ROOT;
      end
      gbm_pkg::BK_ROOT: begin
        if (step_last) state_next = gbm_pkg::BK_DONE;
      end
      gbm_pkg::BK_DONE: begin
        if (!out_valid || pop) state_next = gbm_pkg::BK_IDLE;
      end
      default: state_next = gbm_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state)
      gbm_pkg::BK_IDLE: q_pop    = !q_empty;
      gbm_pkg::BK_DONE: out_load = !out_valid || pop;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gbm_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      gbm_pkg::BK_IDLE: begin
        if (q_pop) begin
          abs1    <= e_a1;
          abs2    <= e_a2;
          neg_cs  <= e_c[CB-1] ^ e_s1[SB-1] ^ e_s2[SB-1];
          ovf_blk <= e_ovf;
          acc     <= '0;
          mcand   <= PW'(e_a1);
          mplier  <= SB'(e_ac);
          mul_sub <= 1'b0;
          count   <= CW'(CB);
        end
      end
      gbm_pkg::BK_MUL_C, gbm_pkg::BK_MUL_CS, gbm_pkg::BK_MUL_SQ1,
      gbm_pkg::BK_MUL_SQ2: begin
        if (!step_last) begin
          acc    <= acc_step;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          count  <= count - CW'(1);
        end else begin
          count <= CW'(SB);
          case (state)
            gbm_pkg::BK_MUL_C: begin
              // |c*s1| becomes the multiplicand for the cross term
              acc     <= '0;
              mcand   <= acc_step;
              mplier  <= abs2;
              mul_sub <= !neg_cs;
            end
            gbm_pkg::BK_MUL_CS: begin
              acc     <= acc_step;
              mcand   <= PW'(abs1) << FB;
              mplier  <= abs1;
              mul_sub <= 1'b0;
            end
            gbm_pkg::BK_MUL_SQ1: begin
              acc     <= acc_step;
              mcand   <= PW'(abs2) << FB;
              mplier  <= abs2;
              mul_sub <= 1'b0;
            end
            default: begin
              acc     <= acc_step;
              mcand   <= '0;
              mplier  <= '0;
              mul_sub <= 1'b0;
            end
          endcase
        end
      end
      gbm_pkg::BK_PREP: begin
        if (acc[PW-1]) begin
          rad <= '0;
        end else if (clip_c) begin
          rad <= '1;
        end else begin
          rad <= q_hi[RAD-1:0];
        end
        clip  <= clip_c;
        rem   <= '0;
        root  <= '0;
        count <= CW'(MB);
      end
      gbm_pkg::BK_ROOT: begin
        rem   <= rem_next;
        root  <= root_next;
        rad   <= rad << 2;
        count <= count - CW'(1);
      end
      gbm_pkg::BK_DONE: begin
        if (out_load) begin
          magnitude <= root;
          saturated <= ovf_blk | clip;
        end
      end
      default: begin
        count <= count;
      end
    endcase
  end

  assign empty = !out_valid;

  a_prep_to_root: assert property (@(posedge clk) disable iff (rst)
    state == gbm_pkg::BK_PREP |=> state == gbm_pkg::BK_ROOT)
    else $error("root stage not entered after prep");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(magnitude) && $stable(saturated))
    else $error("waiting result overwritten");

  a_pop_starts_mul: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == gbm_pkg::BK_MUL_C && count == CW'(CB))
    else $error("queue pop did not start the coefficient multiply");

endmodule

[hw/rtl/goertzel_bin_magnitude.sv]
// goertzel single-bin magnitude. samples stream in on push/full, one item per
// clock while full is low, with last_sample marking the end of a block; the
// recurrence s = x + floor(c*s1 / 2^f) - s2 is computed combinationally for
// each sample and saturates to STATE_BITS. twice_cosine holds c = 2cos(pi*omega)
// in q2.14; the user is to write it with twice_cosine_write only while nothing
// is in flight, and the block itself does not enforce this. on the last sample
// the two state values go into a two-entry queue and the recurrence starts the
// next block at once. a back stage with one shared shift-add multiplier forms
// the exact power (s1^2 + s2^2 - c*s1*s2/2^f) one bit a cycle and then takes a
// restoring square root two bits a cycle. full rises only when both queue
// entries hold blocks not yet taken by the back stage, so blocks arriving
// faster than the back stage takes them stall the input. the result (floor
// root, 0 for a non-positive power, all ones with saturated set when it clips)
// waits in an output register and is taken with pop while empty is low
module goertzel_bin_magnitude #(
  parameter int SAMPLE_BITS        = gbm_pkg::SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRACTION_BITS = gbm_pkg::COEF_FRACTION_BITS_DEFAULT,
  parameter int STATE_BITS         = gbm_pkg::STATE_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample items
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 last_sample,
  // coefficient register
  input  logic                                 twice_cosine_write,
  input  logic signed [gbm_pkg::COEF_BITS-1:0] twice_cosine,
  // result items
  output logic                                 empty,
  input  logic                                 pop,
  output logic [gbm_pkg::MAG_BITS-1:0]         magnitude,
  output logic                                 saturated
);

  // one queue entry per finished block: {overflow, coefficient, s2, s1}
  localparam int ENTRY_BITS = 2 * STATE_BITS + gbm_pkg::COEF_BITS + 1;

  logic                  q_push;
  logic                  q_full;
  logic [ENTRY_BITS-1:0] q_wdata;
  logic                  q_pop;
  logic                  q_empty;
  logic [ENTRY_BITS-1:0] q_rdata;

  // recurrence, coefficient register and saturation tracking
  gbm_front #(
    .SAMPLE_BITS        (SAMPLE_BITS),
    .COEF_FRACTION_BITS (COEF_FRACTION_BITS),
    .STATE_BITS         (STATE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .last_sample (last_sample),
    .cfg_write   (twice_cosine_write),
    .cfg_data    (twice_cosine),
    .q_push      (q_push),
    .q_full      (q_full),
    .q_data      (q_wdata)
  );

  // decouples the per-sample loop from the slow power/root stage
  gbm_queue #(
    .DEPTH (gbm_pkg::QUEUE_DEPTH),
    .WIDTH (ENTRY_BITS)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // exact power, square root and the output register
  gbm_back #(
    .COEF_FRACTION_BITS (COEF_FRACTION_BITS),
    .STATE_BITS         (STATE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .magnitude (magnitude),
    .saturated (saturated)
  );

endmodule
